@@ rtl/utf8_decoration_filter_defines.svh @@
// assertion macros for the utf8 decoration filter
// used by rtl modules that carry concurrent checks, expects clk_i and rst_ni in scope
`ifndef UTF8_DECORATION_FILTER_DEFINES_SVH
`define UTF8_DECORATION_FILTER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define UDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define UDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/udf_pkg.sv @@
// shared types, constants and the code point folding function
// for the utf8 decoration filter; no dependencies
package udf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned MaxOut = 3;
  localparam int unsigned CntW   = 2;

  // register map, byte addresses
  localparam int unsigned     AddrW           = 3;
  localparam logic [AddrW-1:0] RegFilterEnAddr = 3'h0;

  localparam logic [CpW-1:0] CpSqLeft   = 21'h2018;
  localparam logic [CpW-1:0] CpSqRight  = 21'h2019;
  localparam logic [CpW-1:0] CpSqRev    = 21'h201B;
  localparam logic [CpW-1:0] CpDqLeft   = 21'h201C;
  localparam logic [CpW-1:0] CpDqRight  = 21'h201D;
  localparam logic [CpW-1:0] CpDqRev    = 21'h201F;
  localparam logic [CpW-1:0] CpEnDash   = 21'h2013;
  localparam logic [CpW-1:0] CpEmDash   = 21'h2014;
  localparam logic [CpW-1:0] CpMinus    = 21'h2212;
  localparam logic [CpW-1:0] CpEllipsis = 21'h2026;
  localparam logic [CpW-1:0] CpNbsp     = 21'h00A0;
  localparam logic [CpW-1:0] CpFigSp    = 21'h2007;
  localparam logic [CpW-1:0] CpNarrowSp = 21'h202F;
  localparam logic [CpW-1:0] CpAsciiMax = 21'h007F;
  localparam logic [CpW-1:0] CpLatinMin = 21'h00A0;
  localparam logic [CpW-1:0] CpLatinMax = 21'h024F;

  localparam logic [ByteW-1:0] ChApos  = 8'h27;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChDash  = 8'h2D;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] Lead2   = 8'hC0;
  localparam logic [ByteW-1:0] ContTag = 8'h80;

  // results of one input byte, beat 0 goes out first
  typedef struct packed {
    logic [CntW-1:0]              cnt;
    logic [MaxOut-1:0][ByteW-1:0] data;
  } udf_result_t;

  function automatic udf_result_t udf_emit_cp(input logic [CpW-1:0] cp);
    udf_result_t r;
    r = '0;
    if (cp == CpSqLeft || cp == CpSqRight || cp == CpSqRev) begin
      r.cnt = 2'd1; r.data[0] = ChApos;
    end else if (cp == CpDqLeft || cp == CpDqRight || cp == CpDqRev) begin
      r.cnt = 2'd1; r.data[0] = ChQuote;
    end else if (cp == CpEnDash || cp == CpEmDash || cp == CpMinus) begin
      r.cnt = 2'd1; r.data[0] = ChDash;
    end else if (cp == CpEllipsis) begin
      r.cnt = 2'd3; r.data[0] = ChDot; r.data[1] = ChDot; r.data[2] = ChDot;
    end else if (cp == CpNbsp || cp == CpFigSp || cp == CpNarrowSp) begin
      r.cnt = 2'd1; r.data[0] = ChSpace;
    end else if (cp <= CpAsciiMax) begin
      r.cnt = 2'd1; r.data[0] = cp[ByteW-1:0];
    end else if (cp >= CpLatinMin && cp <= CpLatinMax) begin
      r.cnt     = 2'd2;
      r.data[0] = Lead2 | {4'b0, cp[9:6]};
      r.data[1] = ContTag | {2'b0, cp[5:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/utf8_decoration_filter.sv @@
// utf8 decoration filter top level: apb enable register, decoder and
// result register; uses udf_pkg, udf_decode and udf_out_buf
//
// Takes UTF-8 text one byte per beat on the slave stream and returns cleaned
// UTF-8 on the master stream. Curly quotes, dashes, minus sign and ellipsis
// fold to ASCII (ellipsis becomes three dots), no-break, figure and narrow
// spaces become a plain space, ASCII and U+00A0..U+024F are re-encoded in one
// or two bytes, and all other code points, stray continuation bytes and
// sequences broken by a non-continuation byte are dropped without a trace.
// A byte with tlast set ends the text: an unfinished sequence is discarded.
// Each input byte yields zero to three output beats; tlast on the master side
// marks the last beat of one input byte. An input byte is taken when the
// result register is empty or its last beat leaves in that cycle. While the
// master stream does not stall, plain text flows at one byte per clock, and a
// two-byte re-encoding or an ellipsis holds the input until the result
// register, draining one beat per clock, has sent its last beat. Bytes that
// produce nothing are taken under the same rule. Register 0 at address 0,
// filter_enable (reset 1), turns filtering off when cleared: each byte is then
// copied out unchanged as one beat and any pending sequence is cleared. Write
// it only while the block is idle.
module utf8_decoration_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // slave stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] in_byte
  input  logic                      s_axis_tlast,   // in_end
  // master stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
  output logic                      m_axis_tlast,   // run_last
  // apb configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [udf_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import udf_pkg::*;

  logic        enable_q;
  logic        cfg_wr;
  logic        free;
  logic        accept;
  udf_result_t result;

  // apb: single register, word aligned
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[AddrW-1:2] == RegFilterEnAddr[AddrW-1:2]);
  assign prdata = (paddr[AddrW-1:2] == RegFilterEnAddr[AddrW-1:2]) ? {31'b0, enable_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_wr) begin
      enable_q <= pwdata[0];
    end
  end

  // input beat is taken once the result register can hold its run
  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  udf_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .enable_i (enable_q),
    .byte_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .result_o (result)
  );

  // only runs with at least one byte enter the result register
  udf_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && (result.cnt != 2'd0)),
    .result_i      (result),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ rtl/udf_decode.sv @@
// utf8 sequence decoder: holds the partial code point and turns each
// accepted byte into zero to three result bytes; uses udf_pkg
module udf_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      enable_i,
  input  logic [udf_pkg::ByteW-1:0] byte_i,
  input  logic                      end_i,
  output udf_pkg::udf_result_t      result_o
);
  import udf_pkg::*;

  logic [CpW-1:0] acc_q, acc_d;
  logic [1:0]     left_q, left_d;
  logic [CpW-1:0] acc_next;
  logic           is_cont;

  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign acc_next = {acc_q[CpW-7:0], byte_i[5:0]};

  always_comb begin
    acc_d    = acc_q;
    left_d   = left_q;
    result_o = '0;
    if (!enable_i) begin
      acc_d            = '0;
      left_d           = '0;
      result_o.cnt     = 2'd1;
      result_o.data[0] = byte_i;
    end else if (left_q != 2'd0 && is_cont) begin
      acc_d  = acc_next;
      left_d = left_q - 2'd1;
      if (left_q == 2'd1) begin
        result_o = udf_emit_cp(acc_next);
        acc_d    = '0;
      end
    end else begin
      // pending sequence (if any) is dropped, byte is a new lead
      acc_d  = '0;
      left_d = '0;
      if (byte_i[7] == 1'b0) begin
        result_o = udf_emit_cp({13'b0, byte_i});
      end else if (byte_i[7:5] == 3'b110) begin
        acc_d  = {16'b0, byte_i[4:0]};
        left_d = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        acc_d  = {17'b0, byte_i[3:0]};
        left_d = 2'd2;
      end else if (byte_i[7:3] == 5'b11110) begin
        acc_d  = {18'b0, byte_i[2:0]};
        left_d = 2'd3;
      end
    end
    if (end_i) begin
      acc_d  = '0;
      left_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= '0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      left_q <= left_d;
    end
  end

endmodule

@@ rtl/udf_out_buf.sv @@
// result register: holds the bytes of one input and sends them one beat
// at a time on the master stream; uses udf_pkg and the defines header
`include "utf8_decoration_filter_defines.svh"

module udf_out_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  udf_pkg::udf_result_t      result_i,
  output logic                      free_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [udf_pkg::ByteW-1:0] m_axis_tdata,
  output logic                      m_axis_tlast
);
  import udf_pkg::*;

  logic                         valid_q, valid_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [CntW-1:0]              idx_q, idx_d;
  logic [MaxOut-1:0][ByteW-1:0] data_q;
  logic                         last;
  logic                         taken;

  assign last          = (idx_q == cnt_q - 2'd1);
  assign taken         = valid_q && m_axis_tready;
  assign free_o        = !valid_q || (taken && last);
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q[idx_q];
  assign m_axis_tlast  = last;

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    if (taken) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      cnt_d   = result_i.cnt;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i.data;
    end
  end

  `UDF_ASSERT_IMP(a_idx_in_run, valid_q, cnt_q != 2'd0 && idx_q < cnt_q, "beat index outside run")
  `UDF_ASSERT_IMP(a_no_overwrite, load_i, !valid_q || (taken && last), "run overwritten before drained")
  `UDF_ASSERT_IMP(a_load_nonempty, load_i, result_i.cnt != 2'd0, "empty run loaded")
  `UDF_ASSERT_NXT(a_advance, taken && !last, valid_q && idx_q == $past(idx_q) + 2'd1, "run did not advance")

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for utf8_decoration_filter: a scoreboard class that
// predicts the cleaned byte stream and checks it, plus tasks that drive the
// stream and apb ports; depends on udf_pkg and the rtl of the block
`timescale 1ns / 1ps

// mirrors the decoder state and the enable bit, and holds the bytes still owed
class clean_text_tracker;
  bit          filter_on;
  logic [20:0] code_acc;
  logic [1:0]  conts_due;
  logic [7:0]  clean_due[$];
  bit          last_due[$];
  logic [7:0]  run_out[$];
  int          mismatches;

  function new();
    filter_on  = 1'b1;
    code_acc   = '0;
    conts_due  = '0;
    mismatches = 0;
  endfunction

  // fold table first, then plain re-encoding, everything else vanishes
  function void fold_code_point(input logic [20:0] cp);
    case (cp)
      21'h2018, 21'h2019, 21'h201B: run_out.insert(run_out.size(), 8'h27);
      21'h201C, 21'h201D, 21'h201F: run_out.insert(run_out.size(), 8'h22);
      21'h2013, 21'h2014, 21'h2212: run_out.insert(run_out.size(), 8'h2D);
      21'h00A0, 21'h2007, 21'h202F: run_out.insert(run_out.size(), 8'h20);
      21'h2026: begin
        for (int i = 0; i < 3; i++) run_out.insert(run_out.size(), 8'h2E);
      end
      default: begin
        if (cp <= 21'h7F) begin
          run_out.insert(run_out.size(), cp[7:0]);
        end else if (cp >= 21'hA0 && cp <= 21'h24F) begin
          run_out.insert(run_out.size(), {3'b110, 1'b0, cp[9:6]});
          run_out.insert(run_out.size(), {2'b10, cp[5:0]});
        end
      end
    endcase
  endfunction

  function void note_raw_byte(input logic [7:0] raw, input bit eot);
    bit taken;
    taken = 1'b0;
    run_out.delete();
    if (!filter_on) begin
      code_acc  = '0;
      conts_due = '0;
      run_out.insert(run_out.size(), raw);
    end else begin
      if (conts_due != 0) begin
        if (raw[7:6] == 2'b10) begin
          code_acc  = {code_acc[14:0], raw[5:0]};
          conts_due = conts_due - 2'd1;
          if (conts_due == 0) begin
            fold_code_point(code_acc);
            code_acc = '0;
          end
          taken = 1'b1;
        end else begin
          // broken sequence, the byte starts over as a lead
          code_acc  = '0;
          conts_due = '0;
        end
      end
      if (!taken) begin
        if (!raw[7]) begin
          fold_code_point({13'b0, raw});
        end else if (raw[7:5] == 3'b110) begin
          code_acc  = {16'b0, raw[4:0]};
          conts_due = 2'd1;
        end else if (raw[7:4] == 4'b1110) begin
          code_acc  = {17'b0, raw[3:0]};
          conts_due = 2'd2;
        end else if (raw[7:3] == 5'b11110) begin
          code_acc  = {18'b0, raw[2:0]};
          conts_due = 2'd3;
        end
      end
      if (eot) begin
        code_acc  = '0;
        conts_due = '0;
      end
    end
    foreach (run_out[i]) begin
      clean_due.insert(clean_due.size(), run_out[i]);
      last_due.insert(last_due.size(), i == run_out.size() - 1);
    end
  endfunction

  function void check_clean_byte(input logic [7:0] got, input logic got_last);
    logic [7:0] want;
    bit         want_last;
    if (clean_due.size() == 0) begin
      $error("unexpected beat: out_byte %h run_last %b", got, got_last);
      mismatches++;
      return;
    end
    want      = clean_due.pop_front();
    want_last = last_due.pop_front();
    if (got !== want) begin
      $error("out_byte: expected %h, got %h", want, got);
      mismatches++;
    end
    if (got_last !== want_last) begin
      $error("run_last: expected %b, got %b", want_last, got_last);
      mismatches++;
    end
  endfunction

  function int beats_owed();
    return clean_due.size();
  endfunction
endclass

module testbench;

  localparam int ClkHalf     = 4;
  // the monitor ends the test as failed once the cycle count exceeds this limit
  localparam int CycleLimit  = 200000;
  // quiet cycles after the last owed beat, covers bytes that produce nothing
  localparam int DrainCycles = 8;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;   // [7:0] in_byte
  logic                      s_axis_tlast  = 1'b0; // in_end
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [7:0]                m_axis_tdata;         // [7:0] out_byte
  logic                      m_axis_tlast;         // run_last
  logic                      psel          = 1'b0;
  logic                      penable       = 1'b0;
  logic                      pwrite        = 1'b0;
  logic [udf_pkg::AddrW-1:0] paddr         = '0;
  logic [31:0]               pwdata        = '0;
  logic [31:0]               prdata;
  logic                      pready;

  clean_text_tracker tracker;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;    // receiver hold-off, counted down by the receiver process
  int cycle_count;
  logic [7:0] text_q[$];

  always #(ClkHalf) clk_i = ~clk_i;

  utf8_decoration_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // receiver: a long hold-off wins over the random stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: both handshakes are sampled on the edge, before the block updates;
  // an input beat is noted before any output beat of the same edge is checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (s_axis_tvalid && s_axis_tready) tracker.note_raw_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) tracker.check_clean_byte(m_axis_tdata, m_axis_tlast);
      if (cycle_count > CycleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // offers one byte after a random gap and returns on the edge that takes it
  task automatic send_byte(input logic [7:0] raw, input bit eot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tlast  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // apb write, setup then access; the register loads on the access edge
  task automatic write_filter_enable(input bit on);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= udf_pkg::RegFilterEnAddr;
    pwdata  <= {31'b0, on};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.filter_on = on;
  endtask

  // stops offering and waits for every owed beat, then idles for the drain period
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.beats_owed() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // utf-8 encoding at the shortest length, or padded out to an overlong form
  function automatic void add_code_point(input logic [20:0] cp, input bit overlong);
    int len;
    len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    if (overlong && len < 4) len = $urandom_range(4, len + 1);
    case (len)
      1: text_q.insert(text_q.size(), {1'b0, cp[6:0]});
      2: begin
        text_q.insert(text_q.size(), {3'b110, cp[10:6]});
        text_q.insert(text_q.size(), {2'b10, cp[5:0]});
      end
      3: begin
        text_q.insert(text_q.size(), {4'b1110, cp[15:12]});
        text_q.insert(text_q.size(), {2'b10, cp[11:6]});
        text_q.insert(text_q.size(), {2'b10, cp[5:0]});
      end
      default: begin
        text_q.insert(text_q.size(), {5'b11110, cp[20:18]});
        text_q.insert(text_q.size(), {2'b10, cp[17:12]});
        text_q.insert(text_q.size(), {2'b10, cp[11:6]});
        text_q.insert(text_q.size(), {2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // weighted toward ascii, the fold table and the latin range that survives
  function automatic logic [20:0] pick_code_point();
    logic [20:0] cp;
    case ($urandom_range(9))
      0, 1, 2: cp = 21'($urandom_range(8'h7F));
      3: begin
        case ($urandom_range(12))
          0:       cp = 21'h2018;
          1:       cp = 21'h2019;
          2:       cp = 21'h201B;
          3:       cp = 21'h201C;
          4:       cp = 21'h201D;
          5:       cp = 21'h201F;
          6:       cp = 21'h2013;
          7:       cp = 21'h2014;
          8:       cp = 21'h2212;
          9:       cp = 21'h2026;
          10:      cp = 21'h00A0;
          11:      cp = 21'h2007;
          default: cp = 21'h202F;
        endcase
      end
      4, 5: cp = 21'($urandom_range(21'h24F, 21'hA0));
      // c1 controls and the rest of the two-byte range are dropped
      6: cp = 21'($urandom_range(1) ? $urandom_range(21'h9F, 21'h80)
                                    : $urandom_range(21'h7FF, 21'h250));
      7: begin
        case ($urandom_range(3))
          0:       cp = 21'hFFFD;
          1:       cp = 21'($urandom_range(21'hDFFF, 21'hD800));
          default: cp = 21'($urandom_range(21'hFFFF, 21'h800));
        endcase
      end
      default: cp = 21'($urandom_range(21'h1FFFFF, 21'h10000));
    endcase
    return cp;
  endfunction

  // mostly well-formed sequences, some raw noise and truncated sequences; a
  // truncated one is followed by the next item's first byte, so it breaks mid-way
  task automatic send_random_text(input int n_bytes);
    int sent;
    int kind;
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(9);
      if (kind < 8) begin
        add_code_point(pick_code_point(), $urandom_range(7) == 0);
      end else if (kind == 8) begin
        text_q.insert(text_q.size(), 8'($urandom_range(255)));
      end else begin
        add_code_point(pick_code_point(), 1'b0);
        if (text_q.size() > 1) void'(text_q.pop_back());
      end
      while (text_q.size() != 0) begin
        send_byte(text_q.pop_front(), $urandom_range(15) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    tracker       = new();
    send_idle_pct = 23;
    recv_idle_pct = 82;
    hold_left     = 0;
    cycle_count   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 1: sender mostly busy, receiver mostly stalled
    write_filter_enable(1'b1);
    send_byte(8'h00, 1'b0);   // lowest ascii
    send_byte(8'h7F, 1'b0);   // highest ascii
    send_byte(8'hFF, 1'b0);   // invalid lead, dropped
    send_byte(8'h80, 1'b0);   // stray continuation, dropped
    send_byte(8'hC0, 1'b0);   // overlong nul decodes to 00
    send_byte(8'h80, 1'b0);
    send_byte(8'hE2, 1'b0);   // left single quote folds to apostrophe
    send_byte(8'h80, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'hE2, 1'b0);   // ellipsis, three dots from one byte
    send_byte(8'h80, 1'b0);
    send_byte(8'hA6, 1'b0);
    send_byte(8'hC2, 1'b0);   // no-break space becomes a plain space
    send_byte(8'hA0, 1'b0);
    send_byte(8'hC9, 1'b0);   // top of the kept latin range
    send_byte(8'h8F, 1'b0);
    send_byte(8'hC2, 1'b0);   // c1 control, dropped
    send_byte(8'h80, 1'b0);
    send_byte(8'hE2, 1'b0);   // broken sequence, the ascii byte still comes out
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b1);   // lead cut off by end of text
    send_byte(8'hF0, 1'b0);   // four-byte code point, dropped
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_random_text(60);
    // long receiver hold-off while bytes keep coming, so the input stalls
    hold_left = 60;
    send_random_text(90);
    wait_drained();

    // phase 2: the other way round, with a pass-through stretch
    send_idle_pct = 82;
    recv_idle_pct = 23;
    write_filter_enable(1'b0);
    for (int i = 0; i < 60; i++) begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
    wait_drained();
    write_filter_enable(1'b1);
    send_random_text(60);
    wait_drained();

    // phase 3: no random idling, back-to-back beats but for one receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_text(35);
    hold_left = 40;
    send_random_text(35);
    // sender pauses until the block has handed over everything
    wait_drained();
    send_random_text(35);
    wait_drained();

    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
